/* sv/pic_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

   // Register map holds two 32-bit halves for the pending, edge and enable bit vectors
   localparam int MapBits = 64;

   // Bus function codes
   localparam logic [1:0] FUNC_NONE  = 2'd0;
   localparam logic [1:0] FUNC_READ  = 2'd1;
   localparam logic [1:0] FUNC_WRITE = 2'd2;

   // Register map as word indexes (byte offset >> 2)
   localparam logic [7:0] WORD_PEND_LO = 8'h00;
   localparam logic [7:0] WORD_PEND_HI = 8'h01;
   localparam logic [7:0] WORD_EDGE_LO = 8'h02;
   localparam logic [7:0] WORD_EDGE_HI = 8'h03;
   localparam logic [7:0] WORD_PRIO    = 8'h04;
   localparam logic [7:0] WORD_EN_LO   = 8'h80;
   localparam logic [7:0] WORD_EN_HI   = 8'h81;
   localparam logic [7:0] WORD_THRESH  = 8'h82;
   localparam logic [7:0] WORD_CLAIM   = 8'h83;
   localparam logic [7:0] WORD_SOFT    = 8'h84;

   typedef struct packed {
      logic [MapBits-1:0] source_levels;
      logic [31:0]        write_data;
      logic [9:0]         addr;
      logic [1:0]         func;
   } req_item_type;

endpackage

`default_nettype wire

/* sv/platform_interrupt_controller.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Width  Contents (lowest bit first)
// req_     in   112    func[1:0], addr[11:2], write_data[43:12], source_levels[107:44]
// rsp_     out  40     read_data[31:0], irq_line[32], soft_irq[33], zero fill
//
// One item per clock sustained while rsp_tready is high; each item is held in the input register and
// its result then sits in the output register.
// Claim selection is a combinational tree over all sources (log2 NUM_SOURCES levels of
// priority compares); it sets the clock limit together with the gateway update.
// Synchronous reset clears all controller state and both valid flags.
// A stalled result holds the input register; req_tready follows rsp_tready combinationally.
module platform_interrupt_controller
   import pic_pkg::*;
#(
   parameter int NUM_SOURCES  = 64,
   parameter int MAX_PRIORITY = 7
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [111:0] req_tdata,  // func, addr, write_data, source_levels
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [39:0]       rsp_tdata   // read_data, irq_line, soft_irq
);

   localparam int IdW    = (NUM_SOURCES > 2) ? $clog2(NUM_SOURCES) : 1;
   localparam int PrioW  = (MAX_PRIORITY > 1) ? $clog2(MAX_PRIORITY + 1) : 1;
   localparam int Leaves = 1 << IdW;
   localparam int Nodes  = 2 * Leaves - 1;
   localparam logic [NUM_SOURCES-1:0] SrcMask = {{(NUM_SOURCES-1){1'b1}}, 1'b0};
   localparam logic [7:0] PrioEnd = 8'(4 + NUM_SOURCES);
   localparam logic [31:0] MaxPrio = 32'(MAX_PRIORITY);

   // pipeline control
   logic         s1_vld_ff;
   req_item_type s1_ff;
   logic         rsp_vld_ff;
   logic [31:0]  rdata_ff;
   logic         out_free;
   logic         fire;

   // controller state
   logic [NUM_SOURCES-1:0] pend_ff, clm_ff, edge_ff, en_ff, prev_ff;
   logic [PrioW-1:0]       prio_ff [NUM_SOURCES];
   logic [PrioW-1:0]       thr_ff;
   logic                   soft_ff;

   // next values
   logic [NUM_SOURCES-1:0] pend_in, clm_in, edge_in, en_in, req_bits;
   logic [PrioW-1:0]       thr_in;
   logic                   soft_in;
   logic [31:0]            rdata_in;

   logic [7:0]        word;
   logic [7:0]        prio_n;
   logic              prio_hit;
   logic [IdW-1:0]    prio_idx;
   logic              is_rd, is_wr;
   logic [PrioW-1:0]  wr_prio;
   logic [MapBits-1:0] pend64, edge64, en64;
   logic [MapBits-1:0] wr_lo64, wr_hi64;
   logic [NUM_SOURCES-1:0] levels;
   logic [NUM_SOURCES-1:0] gt_bits;
   logic              irq;

   // claim tree (heap order, leaves at Leaves-1 .. Nodes-1)
   logic             node_vld  [Nodes];
   logic [PrioW-1:0] node_prio [Nodes];
   logic [IdW-1:0]   node_id   [Nodes];
   logic             sel_vld;
   logic [IdW-1:0]   sel_id;

   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign req_tready = !s1_vld_ff || out_free;
   assign fire       = s1_vld_ff && out_free;

   assign word     = s1_ff.addr[9:2];
   assign prio_n   = word - WORD_PRIO;
   assign prio_hit = (word >= WORD_PRIO) && (word < PrioEnd);
   assign prio_idx = prio_n[IdW-1:0];
   assign is_rd    = (s1_ff.func == FUNC_READ);
   assign is_wr    = (s1_ff.func == FUNC_WRITE);
   assign wr_prio  = (s1_ff.write_data > MaxPrio) ? PrioW'(MAX_PRIORITY)
                                                  : s1_ff.write_data[PrioW-1:0];
   assign pend64   = MapBits'(pend_ff);
   assign edge64   = MapBits'(edge_ff);
   assign en64     = MapBits'(en_ff);
   assign levels   = s1_ff.source_levels[NUM_SOURCES-1:0];

   genvar gi;
   generate
      for (gi = 0; gi < Leaves; gi++) begin : g_leaf
         if (gi < NUM_SOURCES) begin : g_src
            assign node_vld[Leaves-1+gi]  = pend_ff[gi] && en_ff[gi] && (prio_ff[gi] > thr_ff);
            assign node_prio[Leaves-1+gi] = prio_ff[gi];
         end else begin : g_pad
            assign node_vld[Leaves-1+gi]  = 1'b0;
            assign node_prio[Leaves-1+gi] = '0;
         end
         assign node_id[Leaves-1+gi] = IdW'(gi);
      end
      // lower ID on the left child wins ties
      for (gi = 0; gi < Leaves - 1; gi++) begin : g_node
         logic take_r;
         assign take_r = node_vld[2*gi+2] &&
                         (!node_vld[2*gi+1] || (node_prio[2*gi+2] > node_prio[2*gi+1]));
         assign node_vld[gi]  = node_vld[2*gi+1] || node_vld[2*gi+2];
         assign node_prio[gi] = take_r ? node_prio[2*gi+2] : node_prio[2*gi+1];
         assign node_id[gi]   = take_r ? node_id[2*gi+2] : node_id[2*gi+1];
      end
      for (gi = 0; gi < NUM_SOURCES; gi++) begin : g_gt
         assign gt_bits[gi] = prio_ff[gi] > thr_ff;
      end
   endgenerate

   assign sel_vld = node_vld[0];
   assign sel_id  = node_id[0];

   // state holds the effect of the item now in the output register
   assign irq = |(pend_ff & en_ff & gt_bits);

   always_comb begin
      wr_lo64  = {edge64[63:32], s1_ff.write_data};
      wr_hi64  = {s1_ff.write_data, edge64[31:0]};
      pend_in  = pend_ff;
      clm_in   = clm_ff;
      edge_in  = edge_ff;
      en_in    = en_ff;
      thr_in   = thr_ff;
      soft_in  = soft_ff;
      rdata_in = '0;
      if (is_rd) begin
         case (word)
            WORD_PEND_LO: rdata_in = pend64[31:0];
            WORD_PEND_HI: rdata_in = pend64[63:32];
            WORD_EDGE_LO: rdata_in = edge64[31:0];
            WORD_EDGE_HI: rdata_in = edge64[63:32];
            WORD_EN_LO:   rdata_in = en64[31:0];
            WORD_EN_HI:   rdata_in = en64[63:32];
            WORD_THRESH:  rdata_in = 32'(thr_ff);
            WORD_CLAIM: begin
               if (sel_vld) begin
                  pend_in[sel_id] = 1'b0;
                  clm_in[sel_id]  = 1'b1;
                  rdata_in        = 32'(sel_id);
               end
            end
            WORD_SOFT:    rdata_in = {31'd0, soft_ff};
            default: begin
               if (prio_hit && prio_n != 8'd0) begin
                  rdata_in = 32'(prio_ff[prio_idx]);
               end
            end
         endcase
      end else if (is_wr) begin
         case (word)
            WORD_EDGE_LO: edge_in = NUM_SOURCES'(wr_lo64) & SrcMask;
            WORD_EDGE_HI: edge_in = NUM_SOURCES'(wr_hi64) & SrcMask;
            WORD_EN_LO:   en_in = NUM_SOURCES'({en64[63:32], s1_ff.write_data}) & SrcMask;
            WORD_EN_HI:   en_in = NUM_SOURCES'({s1_ff.write_data, en64[31:0]}) & SrcMask;
            WORD_THRESH:  thr_in = wr_prio;
            WORD_CLAIM: begin
               // complete only an enabled, valid source ID
               if (s1_ff.write_data != 32'd0 && s1_ff.write_data < 32'(NUM_SOURCES)) begin
                  if (en_ff[s1_ff.write_data[IdW-1:0]]) begin
                     clm_in[s1_ff.write_data[IdW-1:0]] = 1'b0;
                  end
               end
            end
            WORD_SOFT:    soft_in = s1_ff.write_data[0];
            default:      ;
         endcase
      end
      // gateways see the state after the bus access
      req_bits = ((edge_in & levels & ~prev_ff) | (~edge_in & levels))
                 & SrcMask & ~pend_in & ~clm_in;
      pend_in  = pend_in | req_bits;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         pend_ff    <= '0;
         clm_ff     <= '0;
         edge_ff    <= '0;
         en_ff      <= '0;
         prev_ff    <= '0;
         thr_ff     <= '0;
         soft_ff    <= 1'b0;
         for (int i = 0; i < NUM_SOURCES; i++) begin
            prio_ff[i] <= '0;
         end
      end else begin
         if (req_tready) begin
            s1_vld_ff <= req_tvalid;
         end
         if (fire) begin
            rsp_vld_ff <= 1'b1;
            pend_ff    <= pend_in;
            clm_ff     <= clm_in;
            edge_ff    <= edge_in;
            en_ff      <= en_in;
            prev_ff    <= levels;
            thr_ff     <= thr_in;
            soft_ff    <= soft_in;
            if (is_wr && prio_hit && prio_n != 8'd0) begin
               prio_ff[prio_idx] <= wr_prio;
            end
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_ff <= req_item_type'(req_tdata[107:0]);
      end
      if (fire) begin
         rdata_ff <= rdata_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, soft_ff, irq, rdata_ff};

   // a source is never pending and claimed at once
   a_pend_clm_excl: assert property (@(posedge clock) disable iff (reset)
      (pend_ff & clm_ff) == '0)
      else $error("source both pending and claimed");

   // source zero never takes part
   a_src_zero: assert property (@(posedge clock) disable iff (reset)
      !pend_ff[0] && !clm_ff[0] && !en_ff[0] && !edge_ff[0])
      else $error("source zero bit set");

   // a granted claim marks the source claimed
   a_claim_marks: assert property (@(posedge clock) disable iff (reset)
      fire && is_rd && word == WORD_CLAIM && sel_vld |=> clm_ff[$past(sel_id)])
      else $error("claimed source not marked");

   // irq implies an enabled pending source
   a_irq_cause: assert property (@(posedge clock) disable iff (reset)
      irq |-> (pend_ff & en_ff) != '0)
      else $error("irq without enabled pending source");

   a_thr_range: assert property (@(posedge clock) disable iff (reset)
      32'(thr_ff) <= MaxPrio)
      else $error("threshold above maximum priority");

endmodule

`default_nettype wire

/* bench/platform_interrupt_controller_test.sv */
`timescale 1ns / 1ps

module platform_interrupt_controller_test;
   import pic_pkg::*;

   localparam int NumSources = 64;
   localparam int MaxPriority = 7;
   localparam logic [63:0] SrcMask = 64'hFFFF_FFFF_FFFF_FFFE;
   localparam logic [1:0] FuncReserved = 2'd3;
   localparam int RandomItems = 1850;
   localparam int IdleLimit = 1000;
   localparam int DrainCycles = 8;
   localparam logic [63:0] AllHigh = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_line;
      logic        soft_irq;
   } pic_resp_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [9:0]  addr;
      logic [31:0] wdata;
      logic [63:0] levels;
      logic        fixed;
      logic [31:0] rdata;
   } plan_row_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [111:0]  req_tdata = '0;   // func, addr, write_data, source_levels, zero fill
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [39:0]   rsp_tdata;        // read_data, irq_line, soft_irq, zero fill

   // Typed read_data for a row of the directed plan travels beside the item
   logic          drv_fixed = 1'b0;
   logic [31:0]   drv_fixed_rdata = '0;

   // Shadow copy of the controller state
   logic [63:0]   pic_pending;
   logic [63:0]   pic_claimed;
   logic [63:0]   pic_edge;
   logic [63:0]   pic_enable;
   logic [2:0]    pic_prio [NumSources];
   logic [2:0]    pic_thresh;
   logic [63:0]   pic_prev_levels;
   logic          pic_soft;

   pic_resp_type  resp_due_q [$];
   int            fail_count = 0;
   int            idle_cycles = 0;
   logic [63:0]   level_drive = '0;
   logic [15:0]   stall_pattern = 16'hFFFF;
   logic [5:0]    stall_step = '0;

   localparam int PlanLen = 25;
   plan_row_type plan [PlanLen] = '{
      '{FUNC_READ,  {WORD_PEND_LO, 2'b00}, 32'h0, AllHigh, 1'b1, 32'h0},
      '{FUNC_READ,  {WORD_PEND_HI, 2'b00}, 32'h0, AllHigh, 1'b0, 32'h0},
      '{FUNC_WRITE, {WORD_PEND_LO, 2'b00}, 32'h0, AllHigh, 1'b1, 32'h0},
      '{FUNC_WRITE, {WORD_PRIO, 2'b00}, 32'h7, 64'h0, 1'b1, 32'h0},
      '{FUNC_READ,  {WORD_PRIO, 2'b00}, 32'h0, 64'h0, 1'b1, 32'h0},
      '{FUNC_WRITE, {8'(WORD_PRIO + 8'd63), 2'b00}, 32'hFFFF_FFFF, 64'h0, 1'b1, 32'h0},
      '{FUNC_READ,  {8'(WORD_PRIO + 8'd63), 2'b00}, 32'h0, 64'h0, 1'b1, 32'h7},
      '{FUNC_WRITE, {8'(WORD_PRIO + 8'd5), 2'b00}, 32'h3, 64'h0, 1'b0, 32'h0},
      '{FUNC_WRITE, {WORD_THRESH, 2'b00}, 32'hFFFF_FFFF, 64'h0, 1'b1, 32'h0},
      '{FUNC_READ,  {WORD_THRESH, 2'b00}, 32'h0, 64'h0, 1'b1, 32'h7},
      '{FUNC_WRITE, {WORD_THRESH, 2'b00}, 32'h2, 64'h0, 1'b0, 32'h0},
      '{FUNC_WRITE, {WORD_EN_LO, 2'b00}, 32'hFFFF_FFFF, 64'h0, 1'b0, 32'h0},
      '{FUNC_WRITE, {WORD_EN_HI, 2'b00}, 32'hFFFF_FFFF, 64'h0, 1'b0, 32'h0},
      '{FUNC_READ,  {WORD_CLAIM, 2'b00}, 32'h0, 64'h0, 1'b0, 32'h0},
      '{FUNC_READ,  {WORD_CLAIM, 2'b00}, 32'h0, 64'h0, 1'b0, 32'h0},
      '{FUNC_READ,  {WORD_CLAIM, 2'b00}, 32'h0, 64'h0, 1'b0, 32'h0},
      '{FUNC_WRITE, {WORD_CLAIM, 2'b00}, 32'd64, 64'h0, 1'b0, 32'h0},
      '{FUNC_WRITE, {WORD_CLAIM, 2'b00}, 32'd63, 64'h0, 1'b0, 32'h0},
      '{FUNC_WRITE, {WORD_EDGE_LO, 2'b00}, 32'hAAAA_AAAA, 64'h0, 1'b0, 32'h0},
      '{FUNC_WRITE, {WORD_EDGE_HI, 2'b00}, 32'h5555_5555, AllHigh, 1'b0, 32'h0},
      '{FUNC_READ,  {WORD_EDGE_HI, 2'b00}, 32'h0, AllHigh, 1'b0, 32'h0},
      '{FuncReserved, {WORD_CLAIM, 2'b00}, 32'd5, 64'h0, 1'b0, 32'h0},
      '{FUNC_WRITE, {WORD_SOFT, 2'b00}, 32'hFFFF_FFFF, 64'h0, 1'b0, 32'h0},
      '{FUNC_READ,  {WORD_SOFT, 2'b11}, 32'h0, 64'h0, 1'b0, 32'h0},
      '{FUNC_READ,  {8'hFF, 2'b00}, 32'h0, AllHigh, 1'b1, 32'h0}
   };

   platform_interrupt_controller dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #5 clock = ~clock;

   function automatic logic [2:0] clamp_priority(input logic [31:0] value);
      return (value > 32'(MaxPriority)) ? 3'(MaxPriority) : value[2:0];
   endfunction

   // Highest priority above threshold among enabled pending sources, lowest ID wins ties
   function automatic logic [5:0] best_source();
      logic [63:0] cand;
      logic [5:0]  best;
      logic [2:0]  best_prio;
      cand = pic_pending & pic_enable & SrcMask;
      best = '0;
      best_prio = pic_thresh;
      for (int i = 1; i < NumSources; i++) begin
         if (cand[i] && pic_prio[i] > best_prio) begin
            best = 6'(i);
            best_prio = pic_prio[i];
         end
      end
      return best;
   endfunction

   function automatic pic_resp_type advance_controller(input req_item_type it);
      logic [7:0]   word;
      logic [5:0]   n;
      logic [5:0]   id;
      logic [63:0]  gate;
      pic_resp_type r;
      word = it.addr[9:2];
      n = 6'(word - WORD_PRIO);
      r = '0;
      if (it.func == FUNC_READ) begin
         if (word == WORD_PEND_LO) r.read_data = pic_pending[31:0];
         else if (word == WORD_PEND_HI) r.read_data = pic_pending[63:32];
         else if (word == WORD_EDGE_LO) r.read_data = pic_edge[31:0];
         else if (word == WORD_EDGE_HI) r.read_data = pic_edge[63:32];
         else if (word >= WORD_PRIO && word < WORD_PRIO + 8'd64)
            r.read_data = (n == 0) ? 32'h0 : {29'b0, pic_prio[n]};
         else if (word == WORD_EN_LO) r.read_data = pic_enable[31:0];
         else if (word == WORD_EN_HI) r.read_data = pic_enable[63:32];
         else if (word == WORD_THRESH) r.read_data = {29'b0, pic_thresh};
         else if (word == WORD_CLAIM) begin
            id = best_source();
            if (id != 0) begin
               pic_pending[id] = 1'b0;
               pic_claimed[id] = 1'b1;
            end
            r.read_data = {26'b0, id};
         end
         else if (word == WORD_SOFT) r.read_data = {31'b0, pic_soft};
      end else if (it.func == FUNC_WRITE) begin
         if (word == WORD_EDGE_LO) pic_edge = {pic_edge[63:32], it.write_data} & SrcMask;
         else if (word == WORD_EDGE_HI) pic_edge = {it.write_data, pic_edge[31:0]} & SrcMask;
         else if (word >= WORD_PRIO && word < WORD_PRIO + 8'd64) begin
            if (n != 0) pic_prio[n] = clamp_priority(it.write_data);
         end
         else if (word == WORD_EN_LO) pic_enable = {pic_enable[63:32], it.write_data} & SrcMask;
         else if (word == WORD_EN_HI) pic_enable = {it.write_data, pic_enable[31:0]} & SrcMask;
         else if (word == WORD_THRESH) pic_thresh = clamp_priority(it.write_data);
         else if (word == WORD_CLAIM) begin
            // complete only a valid ID whose source is enabled
            if (it.write_data != 0 && it.write_data < 32'(NumSources)
                && pic_enable[it.write_data[5:0]])
               pic_claimed[it.write_data[5:0]] = 1'b0;
         end
         else if (word == WORD_SOFT) pic_soft = it.write_data[0];
      end
      gate = (pic_edge & it.source_levels & ~pic_prev_levels) | (~pic_edge & it.source_levels);
      gate &= SrcMask & ~pic_pending & ~pic_claimed;
      pic_pending |= gate;
      pic_prev_levels = it.source_levels;
      r.irq_line = (best_source() != 0);
      r.soft_irq = pic_soft;
      return r;
   endfunction

   // Prefer an ID that is claimed right now so completions actually land
   function automatic logic [31:0] pick_claimed_id();
      int          start;
      logic [5:0]  idx;
      start = $urandom_range(0, 63);
      for (int k = 0; k < 64; k++) begin
         idx = 6'(start + k);
         if (pic_claimed[idx]) return {26'b0, idx};
      end
      return $urandom_range(0, 70);
   endfunction

   function automatic req_item_type make_random_item();
      req_item_type it;
      int           r;
      int           pick;
      logic [7:0]   word;
      r = $urandom_range(0, 99);
      if (r < 60) begin
         repeat ($urandom_range(1, 3)) level_drive[$urandom_range(0, 63)] ^= 1'b1;
      end else if (r < 85) begin
         if (r >= 75) level_drive = {$urandom, $urandom};
      end else if (r < 92) level_drive = '0;
      else level_drive = AllHigh;
      it.source_levels = level_drive;

      r = $urandom_range(0, 99);
      if (r < 25) it.func = FUNC_NONE;
      else if (r < 60) it.func = FUNC_READ;
      else if (r < 95) it.func = FUNC_WRITE;
      else it.func = FuncReserved;

      it.write_data = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         word = WORD_CLAIM;
         if ($urandom_range(0, 9) < 7) it.write_data = pick_claimed_id();
         else if ($urandom_range(0, 1) == 0) it.write_data = $urandom_range(0, 70);
      end else if (pick < 45) begin
         word = ($urandom_range(0, 1) == 0) ? WORD_PEND_LO : WORD_PEND_HI;
      end else if (pick < 55) begin
         word = ($urandom_range(0, 1) == 0) ? WORD_EDGE_LO : WORD_EDGE_HI;
         // keep most sources level-sensitive so claims keep coming
         if ($urandom_range(0, 1) == 0) it.write_data = $urandom & $urandom & $urandom;
      end else if (pick < 70) begin
         word = 8'(WORD_PRIO + 8'($urandom_range(0, 63)));
         if ($urandom_range(0, 99) < 85) it.write_data = $urandom_range(0, MaxPriority);
      end else if (pick < 80) begin
         word = ($urandom_range(0, 1) == 0) ? WORD_EN_LO : WORD_EN_HI;
         if ($urandom_range(0, 4) == 0) it.write_data = '1;
      end else if (pick < 88) begin
         word = WORD_THRESH;
         if ($urandom_range(0, 99) < 85) it.write_data = $urandom_range(0, MaxPriority);
      end else if (pick < 93) begin
         word = WORD_SOFT;
      end else begin
         word = 8'($urandom_range(0, 255));
      end
      it.addr = {word, 2'($urandom_range(0, 3))};
      return it;
   endfunction

   task automatic send_item(input req_item_type it, input logic fixed,
                            input logic [31:0] fixed_rdata);
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, it};
      drv_fixed <= fixed;
      drv_fixed_rdata <= fixed_rdata;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Burst framing: between bursts usually drop valid, sometimes not at all
   task automatic pace_sender(inout int burst_left);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      burst_left--;
   endtask

   initial begin
      req_item_type it;
      int           burst_left;
      pic_pending = '0;
      pic_claimed = '0;
      pic_edge = '0;
      pic_enable = '0;
      for (int i = 0; i < NumSources; i++) pic_prio[i] = '0;
      pic_thresh = '0;
      pic_prev_levels = '0;
      pic_soft = 1'b0;
      burst_left = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         pace_sender(burst_left);
         it.func = plan[i].func;
         it.addr = plan[i].addr;
         it.write_data = plan[i].wdata;
         it.source_levels = plan[i].levels;
         send_item(it, plan[i].fixed, plan[i].rdata);
      end
      for (int i = 0; i < RandomItems; i++) begin
         pace_sender(burst_left);
         send_item(make_random_item(), 1'b0, 32'h0);
      end
      req_tvalid <= 1'b0;

      while (resp_due_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0)
         $display("[platform_interrupt_controller] OK");
      else
         $display("[platform_interrupt_controller] ERROR");
      $finish;
   end

   // Receiver stalls follow a 16-bit pattern, redrawn whenever stall_step wraps to zero
   always @(posedge clock) begin
      if (stall_step == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pattern <= 16'hFFFF;
            1: stall_pattern <= 16'($urandom | $urandom);
            2: stall_pattern <= 16'($urandom);
            default: stall_pattern <= 16'($urandom & $urandom) | 16'h0001;
         endcase
      end
      rsp_tready <= stall_pattern[stall_step[3:0]];
      stall_step <= stall_step + 1'b1;
   end

   always @(posedge clock) begin
      pic_resp_type predicted;
      pic_resp_type due;
      logic         moved;
      moved = 1'b0;
      if (!reset && req_tvalid && req_tready) begin
         predicted = advance_controller(req_tdata[107:0]);
         if (drv_fixed) predicted.read_data = drv_fixed_rdata;
         resp_due_q.push_back(predicted);
         moved = 1'b1;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         moved = 1'b1;
         if (resp_due_q.size() == 0) begin
            $error("unexpected result item: %h", rsp_tdata);
            fail_count++;
         end else begin
            due = resp_due_q.pop_front();
            if (rsp_tdata[31:0] !== due.read_data) begin
               $error("read_data: expected %h, actual %h", due.read_data, rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[32] !== due.irq_line) begin
               $error("irq_line: expected %b, actual %b", due.irq_line, rsp_tdata[32]);
               fail_count++;
            end
            if (rsp_tdata[33] !== due.soft_irq) begin
               $error("soft_irq: expected %b, actual %b", due.soft_irq, rsp_tdata[33]);
               fail_count++;
            end
         end
      end
      if (moved) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
         $display("[platform_interrupt_controller] ERROR");
         $finish;
      end
   end

endmodule
